@@ rtl/core/tfh_pkg.sv @@
package tfh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 10;
  localparam int unsigned KeyWords = NumWords + 1;

  // tuple kind carried in the command field
  typedef enum logic [1:0] {
    CMD_IPV4       = 2'd0,
    CMD_IPV4_PORTS = 2'd1,
    CMD_IPV6       = 2'd2,
    CMD_IPV6_PORTS = 2'd3
  } cmd_e;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] word_vec_t;

  typedef struct packed {
    logic [7:0]  trace_tag;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [63:0] dst_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] src_addr_hi;
    logic [1:0]  command;
  } tuple_t;

  // key word 0 is consumed first
  localparam logic [WordW-1:0] HashKey [KeyWords] = '{
    32'h4439796b, 32'hb54c5023, 32'hb675ea5b, 32'h124f9f30,
    32'hb8a2c03d, 32'hdfdc4d02, 32'ha08c9b33, 32'h4af64a4c,
    32'h05c6fa34, 32'h3958d855, 32'h7d99583a
  };

  // contribution of one word; win holds the two key words it sweeps over
  function automatic word_t word_hash(input word_t w, input logic [2*WordW-1:0] win);
    word_t acc;
    acc = '0;
    for (int i = 0; i < WordW; i++) begin
      if (w[WordW-1-i]) begin
        acc = acc ^ win[2*WordW-1-i -: WordW];
      end
    end
    return acc;
  endfunction

endpackage

@@ rtl/core/toeplitz_flow_hash.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   304    flow tuple (command, addresses, ports, trace tag)
// m_axis    out  32     Toeplitz hash of the selected word sequence
//
// One transaction per cycle sustained while m_axis_tready_i stays high; three
// register stages: word selection, per-word key lanes, XOR reduction.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
// Each stage holds its data while the stage after it is full and stalled;
// empty stages fill up, so stalls lose and repeat nothing.
module toeplitz_flow_hash (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [1:0] command, [65:2] src_addr_hi, [129:66] src_addr_lo,
  // [193:130] dst_addr_hi, [257:194] dst_addr_lo, [273:258] src_port,
  // [289:274] dst_port, [297:290] trace_tag, [303:298] zero
  input  logic [303:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] hash_value
  output logic [31:0]  m_axis_tdata_o
);

  tfh_pkg::tuple_t    tuple;
  tfh_pkg::word_vec_t words;
  tfh_pkg::word_vec_t partial;
  logic               sel_valid, sel_ready;
  logic               lane_valid, lane_ready;
  logic               red_ready;

  // struct field order matches the tdata packing, padding dropped
  assign tuple = s_axis_tdata_i[297:0];

  // stage 1: arrange the tuple into word slots for its command
  tfh_word_sel u_word_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .tuple_i     (tuple),
    .out_valid_o (sel_valid),
    .out_ready_i (sel_ready),
    .words_o     (words)
  );

  // stage 2: each word against its 64-bit key window
  tfh_lane_hash u_lane_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid),
    .in_ready_o  (sel_ready),
    .words_i     (words),
    .out_valid_o (lane_valid),
    .out_ready_i (lane_ready),
    .partial_o   (partial)
  );

  // stage 3: fold lanes into the hash, doubles as the output register
  tfh_xor_reduce u_xor_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lane_valid),
    .in_ready_o  (lane_ready),
    .partial_i   (partial),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (red_ready),
    .hash_o      (m_axis_tdata_o)
  );

  assign red_ready = m_axis_tready_i;

  // back-pressure at the input only when every stage is full
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (sel_valid && lane_valid && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while pipeline has room");

  a_sel_to_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_valid && sel_ready) |=> lane_valid)
    else $error("stage 1 transaction lost");

  a_lane_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid && lane_ready) |=> m_axis_tvalid_o)
    else $error("stage 2 transaction lost");

endmodule

@@ rtl/core/tfh_word_sel.sv @@
module tfh_word_sel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tfh_pkg::tuple_t    tuple_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tfh_pkg::word_vec_t words_o
);

  tfh_pkg::word_vec_t words_d, words_q;
  logic               valid_q;
  tfh_pkg::word_t     port_word;
  tfh_pkg::word_t     trace_word;

  assign port_word  = {tuple_i.src_port, tuple_i.dst_port};
  assign trace_word = {24'd0, tuple_i.trace_tag};

  // unused word slots stay zero and add nothing to the hash
  always_comb begin
    words_d = '0;
    case (tfh_pkg::cmd_e'(tuple_i.command))
      tfh_pkg::CMD_IPV4_PORTS: begin
        words_d[0] = tuple_i.src_addr_lo[31:0];
        words_d[1] = tuple_i.dst_addr_lo[31:0];
        words_d[2] = port_word;
        words_d[3] = trace_word;
      end
      tfh_pkg::CMD_IPV6: begin
        words_d[0] = tuple_i.src_addr_hi[63:32];
        words_d[1] = tuple_i.src_addr_hi[31:0];
        words_d[2] = tuple_i.src_addr_lo[63:32];
        words_d[3] = tuple_i.src_addr_lo[31:0];
        words_d[4] = tuple_i.dst_addr_hi[63:32];
        words_d[5] = tuple_i.dst_addr_hi[31:0];
        words_d[6] = tuple_i.dst_addr_lo[63:32];
        words_d[7] = tuple_i.dst_addr_lo[31:0];
        words_d[8] = trace_word;
      end
      tfh_pkg::CMD_IPV6_PORTS: begin
        words_d[0] = tuple_i.src_addr_hi[63:32];
        words_d[1] = tuple_i.src_addr_hi[31:0];
        words_d[2] = tuple_i.src_addr_lo[63:32];
        words_d[3] = tuple_i.src_addr_lo[31:0];
        words_d[4] = tuple_i.dst_addr_hi[63:32];
        words_d[5] = tuple_i.dst_addr_hi[31:0];
        words_d[6] = tuple_i.dst_addr_lo[63:32];
        words_d[7] = tuple_i.dst_addr_lo[31:0];
        words_d[8] = port_word;
        words_d[9] = trace_word;
      end
      default: begin
        words_d[0] = tuple_i.src_addr_lo[31:0];
        words_d[1] = tuple_i.dst_addr_lo[31:0];
        words_d[2] = trace_word;
      end
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      words_q <= words_d;
    end
  end

  assign out_valid_o = valid_q;
  assign words_o     = words_q;

endmodule

@@ rtl/core/tfh_lane_hash.sv @@
module tfh_lane_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tfh_pkg::word_vec_t words_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tfh_pkg::word_vec_t partial_o
);

  tfh_pkg::word_vec_t partial_d, partial_q;
  logic               valid_q;

  // one lane per word position, each against its own key window
  for (genvar j = 0; j < tfh_pkg::NumWords; j++) begin : g_lane
    assign partial_d[j] = tfh_pkg::word_hash(words_i[j],
                                             {tfh_pkg::HashKey[j], tfh_pkg::HashKey[j+1]});
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      partial_q <= partial_d;
    end
  end

  assign out_valid_o = valid_q;
  assign partial_o   = partial_q;

endmodule

@@ rtl/core/tfh_xor_reduce.sv @@
module tfh_xor_reduce (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tfh_pkg::word_vec_t partial_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tfh_pkg::word_t     hash_o
);

  tfh_pkg::word_t hash_d, hash_q;
  logic           valid_q;

  always_comb begin
    hash_d = '0;
    for (int j = 0; j < tfh_pkg::NumWords; j++) begin
      hash_d = hash_d ^ partial_i[j];
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hash_q <= hash_d;
    end
  end

  assign out_valid_o = valid_q;
  assign hash_o      = hash_q;

endmodule

@@ verif/toeplitz_flow_hash_checker.sv @@
`timescale 1ns / 1ps

module toeplitz_flow_hash_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // [297:0] tuple_t (command lowest), [303:298] zero
  input  logic [303:0] s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // [31:0] hash_value
  input  logic [31:0]  m_axis_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int unsigned MaxReports = 10;

  // key word 0 is swept first
  localparam logic [31:0] RssKey [11] = '{
    32'h4439796b, 32'hb54c5023, 32'hb675ea5b, 32'h124f9f30,
    32'hb8a2c03d, 32'hdfdc4d02, 32'ha08c9b33, 32'h4af64a4c,
    32'h05c6fa34, 32'h3958d855, 32'h7d99583a
  };

  logic [31:0] pending_hashes [$];

  function automatic logic [31:0] flow_hash(input tfh_pkg::tuple_t t);
    logic [31:0]    words [10];
    logic [63:0]    window;
    logic [31:0]    acc;
    int             n;
    tfh_pkg::cmd_e  kind;
    kind = tfh_pkg::cmd_e'(t.command);
    n    = 0;
    acc  = '0;
    if (kind == tfh_pkg::CMD_IPV4 || kind == tfh_pkg::CMD_IPV4_PORTS) begin
      words[0] = t.src_addr_lo[31:0];
      words[1] = t.dst_addr_lo[31:0];
      n = 2;
    end else begin
      words[0] = t.src_addr_hi[63:32];
      words[1] = t.src_addr_hi[31:0];
      words[2] = t.src_addr_lo[63:32];
      words[3] = t.src_addr_lo[31:0];
      words[4] = t.dst_addr_hi[63:32];
      words[5] = t.dst_addr_hi[31:0];
      words[6] = t.dst_addr_lo[63:32];
      words[7] = t.dst_addr_lo[31:0];
      n = 8;
    end
    if (kind == tfh_pkg::CMD_IPV4_PORTS || kind == tfh_pkg::CMD_IPV6_PORTS) begin
      words[n] = {t.src_port, t.dst_port};
      n++;
    end
    words[n] = {24'd0, t.trace_tag};
    n++;
    for (int j = 0; j < n; j++) begin
      window = {RssKey[j], RssKey[j+1]};
      for (int i = 0; i < 32; i++) begin
        if (words[j][31-i]) acc ^= window[63-i -: 32];
      end
    end
    return acc;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // results are checked before the new tuple is queued: the DUT registers every
  // tuple before its hash comes out, so a result can never belong to a tuple taken at the same edge
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_hashes.size() == 0) begin
          if (fail_count_o < MaxReports)
            $display("unexpected hash %08h with nothing pending", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = pending_hashes.pop_front();
          if (m_axis_tdata_i !== want) begin
            if (fail_count_o < MaxReports)
              $display("hash mismatch: expected %08h got %08h", want, m_axis_tdata_i);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        pending_hashes.push_back(flow_hash(
          tfh_pkg::tuple_t'(s_axis_tdata_i[$bits(tfh_pkg::tuple_t)-1:0])));
      pending_o = pending_hashes.size();
    end
  end

endmodule

@@ verif/toeplitz_flow_hash_test.sv @@
`timescale 1ns / 1ps

module toeplitz_flow_hash_test;

  localparam int unsigned RandomTuples = 1750;
  localparam int unsigned MaxGap       = 14;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [303:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  int           fail_count;
  int           pending;

  // stretches of back-to-back transactions, one counter per side
  int           send_calm = 0;
  int           recv_calm = 0;

  toeplitz_flow_hash dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // predicts every hash from the accepted tuples and scores the results
  toeplitz_flow_hash_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("toeplitz_flow_hash_test: FAIL");
    $finish;
  end

  // idle cycles before the next transaction; now and then a calm stretch
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MaxGap);
  endfunction

  // addresses lean on all-zero and all-one words now and then
  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom, 32'd0};
      3:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic tfh_pkg::tuple_t rand_tuple();
    tfh_pkg::tuple_t t;
    t.command     = tfh_pkg::cmd_e'($urandom_range(0, 3));
    t.src_addr_hi = rand_addr();
    t.src_addr_lo = rand_addr();
    t.dst_addr_hi = rand_addr();
    t.dst_addr_lo = rand_addr();
    t.src_port    = 16'($urandom_range(0, 65535));
    t.dst_port    = 16'($urandom_range(0, 65535));
    t.trace_tag   = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic tfh_pkg::tuple_t pack_tuple(input tfh_pkg::cmd_e kind,
                                                 input logic [63:0] shi,
                                                 input logic [63:0] slo,
                                                 input logic [63:0] dhi,
                                                 input logic [63:0] dlo,
                                                 input logic [15:0] sp,
                                                 input logic [15:0] dp,
                                                 input logic [7:0] tag);
    tfh_pkg::tuple_t t;
    t.command     = kind;
    t.src_addr_hi = shi;
    t.src_addr_lo = slo;
    t.dst_addr_hi = dhi;
    t.dst_addr_lo = dlo;
    t.src_port    = sp;
    t.dst_port    = dp;
    t.trace_tag   = tag;
    return t;
  endfunction

  // one transaction on the slave side; valid stays high across
  // back-to-back tuples and drops only when a gap is drawn
  task automatic send_tuple(input tfh_pkg::tuple_t t);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold off the sender until every predicted hash has been scored;
  // the extra edge lets the checker queue the last accepted tuple
  task automatic drain_hashes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // master side: random back-pressure, one draw per result
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    tfh_pkg::cmd_e kind;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of every field under every tuple kind
    kind = kind.first();
    do begin
      send_tuple(pack_tuple(kind, '0, '0, '0, '0, '0, '0, '0));
      send_tuple(pack_tuple(kind, '1, '1, '1, '1, '1, '1, '1));
      send_tuple(pack_tuple(kind, {16{4'ha}}, {16{4'h5}}, {16{4'h5}}, {16{4'ha}},
                            16'hffff, 16'h0000, 8'h80));
      kind = kind.next();
    end while (kind != kind.first());

    // IPv4 ignores the upper address halves: same hash with and without junk
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV4, '0, 64'h0000_0000_c0a8_0001, '0,
                          64'h0000_0000_0a00_0002, 16'd80, 16'd443, 8'h11));
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV4, '1, 64'hdead_beef_c0a8_0001, '1,
                          64'hcafe_f00d_0a00_0002, 16'd1, 16'd2, 8'h11));
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV4_PORTS, '1, 64'hffff_ffff_c0a8_0001, '1,
                          64'hffff_ffff_0a00_0002, 16'd80, 16'd443, 8'h22));
    // ports ignored for the port-less kinds
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV6, 64'h2001_0db8_0000_0000, 64'h1,
                          64'h2001_0db8_0000_0001, 64'h2, 16'hffff, 16'hffff, 8'h33));
    // single bits at the first and last key positions
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV6_PORTS, 64'h8000_0000_0000_0000,
                          '0, '0, '0, '0, '0, 8'h01));
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV4, '0, '0, '0, '0, '0, '0, 8'h01));
    send_tuple(pack_tuple(tfh_pkg::CMD_IPV4_PORTS, '0, '0, '0, '0,
                          16'h8000, 16'h0001, '0));

    // sender waits out the pipeline completely once
    drain_hashes();

    for (int n = 0; n < RandomTuples; n++) begin
      if (n == RandomTuples / 2) drain_hashes();
      send_tuple(rand_tuple());
    end

    drain_hashes();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("toeplitz_flow_hash_test: PASS");
    end else begin
      $display("toeplitz_flow_hash_test: FAIL");
    end
    $finish;
  end

endmodule
